/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while in reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/mlfq_pkg.sv */
package mlfq_pkg;

  localparam int NUM_LEVELS_DEF = 4;
  localparam int MAX_TASKS_DEF  = 16;

  localparam int MODE_W   = 3;
  localparam int TASK_W   = 4;
  localparam int OLVL_W   = 2;
  localparam int QUANT_W  = 8;
  localparam int NUM_QUANTA = 4;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UNBLOCK = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BLOCK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EXIT    = 3'd4;

  localparam logic [2:0] REG_LEVELS = 3'd0;
  localparam logic [2:0] REG_Q0     = 3'd1;
  localparam logic [2:0] REG_Q1     = 3'd2;
  localparam logic [2:0] REG_Q2     = 3'd3;
  localparam logic [2:0] REG_Q3     = 3'd4;

  localparam logic [2:0]         LEVELS_RST = 3'd4;
  localparam logic [QUANT_W-1:0] Q0_RST     = 8'd1;
  localparam logic [QUANT_W-1:0] Q1_RST     = 8'd2;
  localparam logic [QUANT_W-1:0] Q2_RST     = 8'd4;
  localparam logic [QUANT_W-1:0] Q3_RST     = 8'd8;

  typedef logic [QUANT_W-1:0] quanta_t [NUM_QUANTA];

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_PICK = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

endpackage

/* src/multilevel_feedback_scheduler.sv */
// Multilevel feedback queue scheduler for one CPU. Each input word is an event (load, unblock,
// tick, block, exit) and yields one output word with the task that runs afterwards. An event
// passes through the idle state, which reads the return level table, and the exec state, which
// does the update and the priority scan; when a task is taken from a queue (tick on expiry
// with requeue or while idle, block, exit, each with a queued task to pick) the pick state
// follows and takes the picked task from the queue memory, whose read is registered. A word
// held at the output waits in the hold state until it is taken.
// The return level table is cleared at reset through per-entry valid bits, so no clearing
// pass is needed; the level queues start empty.
`include "assert_macros.svh"

module multilevel_feedback_scheduler #(
  parameter int NUM_LEVELS = mlfq_pkg::NUM_LEVELS_DEF,
  parameter int MAX_TASKS  = mlfq_pkg::MAX_TASKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mlfq_pkg::MODE_W-1:0]  in_mode,
  input  logic [mlfq_pkg::TASK_W-1:0]  in_task_id,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mlfq_pkg::TASK_W-1:0]  out_running_task,
  output logic                         out_idle,
  output logic [mlfq_pkg::OLVL_W-1:0]  out_running_level,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mlfq_pkg::APB_AW-1:0]  paddr,
  input  logic [mlfq_pkg::APB_DW-1:0]  pwdata,
  output logic [mlfq_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import mlfq_pkg::*;

  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int LN_W   = $clog2(NUM_LEVELS + 1);
  localparam int CW     = LVL_W + LN_W + 1;
  localparam int TID_W  = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int ACT_W  = $clog2(2 * MAX_TASKS);
  localparam int ACT_MAX = 2 * MAX_TASKS - 1;
  localparam int DEPTH  = NUM_LEVELS * MAX_TASKS;
  localparam int ADDR_W = $clog2(DEPTH);

  function automatic logic [TASK_W-1:0] task_mod(input logic [TASK_W-1:0] t);
    int unsigned v;
    v = 32'(t);
    for (int k = 0; k < 8; k++) begin
      if (v >= MAX_TASKS) begin
        v = v - MAX_TASKS;
      end
    end
    return TASK_W'(v);
  endfunction

  function automatic logic [TID_W-1:0] tid_idx(input logic [TASK_W-1:0] t);
    logic [TID_W+TASK_W-1:0] w;
    w = {{TID_W{1'b0}}, t};
    return w[TID_W-1:0];
  endfunction

  function automatic logic [QUANT_W-1:0] slice_of(input logic [LVL_W-1:0] lvl,
                                                  input quanta_t q);
    logic [LVL_W+1:0] lw;
    lw = {2'b00, lvl};
    if (lw < (LVL_W+2)'(4)) begin
      return q[lw[1:0]];
    end
    return q[3];
  endfunction

  function automatic logic [ADDR_W-1:0] st_addr(input logic [LVL_W-1:0] lvl,
                                                input logic [TID_W-1:0] ptr);
    return ADDR_W'(lvl) * ADDR_W'(MAX_TASKS) + ADDR_W'(ptr);
  endfunction

  function automatic logic [TID_W-1:0] ptr_inc(input logic [TID_W-1:0] p);
    return (p == TID_W'(MAX_TASKS - 1)) ? '0 : p + TID_W'(1);
  endfunction

  // configuration registers
  logic [2:0] levels_r;
  quanta_t    q_r;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= LEVELS_RST;
      q_r[0]   <= Q0_RST;
      q_r[1]   <= Q1_RST;
      q_r[2]   <= Q2_RST;
      q_r[3]   <= Q3_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_LEVELS: levels_r <= pwdata[2:0];
        REG_Q0:     q_r[0]   <= pwdata[QUANT_W-1:0];
        REG_Q1:     q_r[1]   <= pwdata[QUANT_W-1:0];
        REG_Q2:     q_r[2]   <= pwdata[QUANT_W-1:0];
        REG_Q3:     q_r[3]   <= pwdata[QUANT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LEVELS: prdata = APB_DW'(levels_r);
      REG_Q0:     prdata = APB_DW'(q_r[0]);
      REG_Q1:     prdata = APB_DW'(q_r[1]);
      REG_Q2:     prdata = APB_DW'(q_r[2]);
      REG_Q3:     prdata = APB_DW'(q_r[3]);
      default:    prdata = '0;
    endcase
  end

  // scheduler state
  state_t             state_r, state_nxt;
  logic [MODE_W-1:0]  mode_r;
  logic [TASK_W-1:0]  task_r;
  logic [TASK_W-1:0]  cur_task_r, cur_task_nxt;
  logic               cur_idle_r, cur_idle_nxt;
  logic [LVL_W-1:0]   cur_level_r, cur_level_nxt;
  logic [QUANT_W-1:0] rq_r, rq_nxt;
  logic [ACT_W-1:0]   active_r, active_nxt;
  logic [CNT_W-1:0]   cnt_r [NUM_LEVELS];
  logic [CNT_W-1:0]   cnt_nxt [NUM_LEVELS];
  logic [CNT_W-1:0]   cnt_after [NUM_LEVELS];
  logic [TID_W-1:0]   head_r [NUM_LEVELS];
  logic [TID_W-1:0]   head_nxt [NUM_LEVELS];
  logic [TID_W-1:0]   tail_r [NUM_LEVELS];
  logic [TID_W-1:0]   tail_nxt [NUM_LEVELS];
  logic               fwd_r;
  logic [TASK_W-1:0]  fwd_task_r;

  logic               out_valid_r, out_valid_nxt;
  logic [TASK_W-1:0]  out_task_r;
  logic               out_idle_r;
  logic [OLVL_W-1:0]  out_level_r;
  logic               out_load;
  logic               out_free;

  // queue store and return level table
  logic [TASK_W-1:0]  st_mem [DEPTH];
  logic [TASK_W-1:0]  st_rdata_r;
  logic               st_we;
  logic [ADDR_W-1:0]  st_waddr;
  logic [ADDR_W-1:0]  st_raddr;
  logic [LVL_W-1:0]   rt_mem [MAX_TASKS];
  logic               rt_vld_r [MAX_TASKS];
  logic [LVL_W-1:0]   rt_rdata_r;
  logic               rt_hit_r;
  logic               rt_we;
  logic [TID_W-1:0]   rt_waddr;
  logic [LVL_W-1:0]   rt_wdata;
  logic [TID_W-1:0]   rt_raddr;
  logic [LVL_W-1:0]   rt_level;

  logic               exec;
  logic               accept;
  logic [LN_W-1:0]    n_eff;
  logic [CW-1:0]      up_w;
  logic [CW-1:0]      nm1_w;
  logic [LVL_W-1:0]   dem_lvl;
  logic [LVL_W-1:0]   ret_lvl;
  logic               expire;
  logic               push_req;
  logic [LVL_W-1:0]   push_lvl;
  logic [TASK_W-1:0]  push_task;
  logic               push_ok;
  logic               pick_req;
  logic               pick_go;
  logic               found;
  logic [LVL_W-1:0]   pick_lvl;
  logic [OLVL_W+LVL_W-1:0] olvl_w;

  assign exec     = (state_r == ST_EXEC);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign rt_raddr = tid_idx(task_mod(in_task_id));
  assign rt_level = rt_hit_r ? rt_rdata_r : '0;

  assign n_eff = (levels_r == 3'd0) ? LN_W'(1) :
                 (32'(levels_r) > NUM_LEVELS) ? LN_W'(NUM_LEVELS) : LN_W'(levels_r);
  assign up_w    = CW'(cur_level_r) + CW'(1);
  assign nm1_w   = CW'(n_eff) - CW'(1);
  assign dem_lvl = LVL_W'((up_w < nm1_w) ? up_w : nm1_w);
  assign ret_lvl = (cur_level_r <= LVL_W'(1)) ? '0 : cur_level_r - LVL_W'(1);
  assign expire  = !cur_idle_r && (rq_r <= QUANT_W'(1));

  // what the event pushes and whether it picks
  always_comb begin
    push_req  = 1'b0;
    push_lvl  = '0;
    push_task = cur_task_r;
    pick_req  = 1'b0;
    case (mode_r)
      MODE_LOAD: begin
        push_req  = 1'b1;
        push_task = task_r;
      end
      MODE_UNBLOCK: begin
        push_req  = 1'b1;
        push_lvl  = rt_level;
        push_task = task_r;
      end
      MODE_TICK: begin
        if (cur_idle_r) begin
          pick_req = 1'b1;
        end else if (expire) begin
          push_req = (active_r > ACT_W'(1));
          push_lvl = dem_lvl;
        end
      end
      MODE_BLOCK, MODE_EXIT: pick_req = 1'b1;
      default: ;
    endcase
  end

  assign push_ok = exec && push_req && (cnt_r[push_lvl] < CNT_W'(MAX_TASKS));
  assign pick_go = exec && (pick_req || (mode_r == MODE_TICK && push_ok));

  // priority scan over occupancy after the push
  always_comb begin
    found    = 1'b0;
    pick_lvl = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      cnt_after[i] = cnt_r[i] + CNT_W'(push_ok && (push_lvl == LVL_W'(i)));
      if (!found && (LN_W'(i) < n_eff) && (cnt_after[i] != '0)) begin
        found    = 1'b1;
        pick_lvl = LVL_W'(i);
      end
    end
  end

  assign st_we    = push_ok;
  assign st_waddr = st_addr(push_lvl, tail_r[push_lvl]);
  assign st_raddr = st_addr(pick_lvl, head_r[pick_lvl]);

  always_comb begin
    state_nxt     = state_r;
    cur_task_nxt  = cur_task_r;
    cur_idle_nxt  = cur_idle_r;
    cur_level_nxt = cur_level_r;
    rq_nxt        = rq_r;
    active_nxt    = active_r;
    rt_we         = 1'b0;
    rt_waddr      = tid_idx(task_r);
    rt_wdata      = '0;
    out_load      = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      cnt_nxt[i]  = cnt_after[i];
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
      if (push_ok && (push_lvl == LVL_W'(i))) begin
        tail_nxt[i] = ptr_inc(tail_r[i]);
      end
      if (pick_go && found && (pick_lvl == LVL_W'(i))) begin
        cnt_nxt[i]  = cnt_after[i] - CNT_W'(1);
        head_nxt[i] = ptr_inc(head_r[i]);
      end
    end

    if (exec) begin
      case (mode_r)
        MODE_LOAD: begin
          rt_we = 1'b1;
          if (push_ok && (active_r < ACT_W'(ACT_MAX))) begin
            active_nxt = active_r + ACT_W'(1);
          end
        end
        MODE_UNBLOCK: begin
          if (push_ok && (active_r < ACT_W'(ACT_MAX))) begin
            active_nxt = active_r + ACT_W'(1);
          end
        end
        MODE_TICK: begin
          if (expire && !push_ok) begin
            cur_level_nxt = dem_lvl;
            rq_nxt        = slice_of(dem_lvl, q_r);
          end else if (!cur_idle_r && !expire) begin
            rq_nxt = rq_r - QUANT_W'(1);
          end
        end
        MODE_BLOCK, MODE_EXIT: begin
          if (!cur_idle_r) begin
            if (active_r != '0) begin
              active_nxt = active_r - ACT_W'(1);
            end
            if (mode_r == MODE_BLOCK) begin
              rt_we    = 1'b1;
              rt_waddr = tid_idx(cur_task_r);
              rt_wdata = ret_lvl;
            end
          end
        end
        default: ;
      endcase

      if (pick_go) begin
        if (found) begin
          cur_idle_nxt  = 1'b0;
          cur_level_nxt = pick_lvl;
          rq_nxt        = slice_of(pick_lvl, q_r);
        end else begin
          cur_idle_nxt  = 1'b1;
          cur_task_nxt  = '0;
          cur_level_nxt = '0;
        end
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (pick_go && found) begin
          state_nxt = ST_PICK;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_PICK: begin
        cur_task_nxt = fwd_r ? fwd_task_r : st_rdata_r;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = (out_valid_r && !out_ready) || out_load;
  end

  assign olvl_w = {{OLVL_W{1'b0}}, cur_level_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_task_r  <= '0;
      cur_idle_r  <= 1'b1;
      cur_level_r <= '0;
      rq_r        <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        cnt_r[i]  <= '0;
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cur_task_r  <= cur_task_nxt;
      cur_idle_r  <= cur_idle_nxt;
      cur_level_r <= cur_level_nxt;
      rq_r        <= rq_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        cnt_r[i]  <= cnt_nxt[i];
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      task_r <= task_mod(in_task_id);
    end
    if (exec) begin
      fwd_r      <= push_ok && (pick_lvl == push_lvl) && (cnt_r[push_lvl] == '0);
      fwd_task_r <= push_task;
    end
    if (out_load) begin
      out_task_r  <= cur_idle_nxt ? '0 : cur_task_nxt;
      out_idle_r  <= cur_idle_nxt;
      out_level_r <= cur_idle_nxt ? '0 : olvl_w[OLVL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= push_task;
    end
    st_rdata_r <= st_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (rt_we) begin
      rt_mem[rt_waddr] <= rt_wdata;
    end
    rt_rdata_r <= rt_mem[rt_raddr];
    rt_hit_r   <= rt_vld_r[rt_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        rt_vld_r[i] <= 1'b0;
      end
    end else if (rt_we) begin
      rt_vld_r[rt_waddr] <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_running_task  = out_task_r;
  assign out_idle          = out_idle_r;
  assign out_running_level = out_level_r;

  `ASSERT_CLK(a_accept_to_exec, accept |=> state_r == ST_EXEC, "accepted word did not start")
  `ASSERT_CLK(a_pick_after_exec, state_r == ST_PICK |-> $past(state_r) == ST_EXEC, "stray pick")
  `ASSERT_CLK(a_out_from_work, $rose(out_valid_r) |-> $past(state_r) != ST_IDLE, "stray word")
  `ASSERT_NEVER(a_idle_level, cur_idle_r && (cur_level_r != '0), "idle with nonzero level")

endmodule
